FILE: design/fys_pkg.sv
// Shared constants and types for the Fisher-Yates index sampler.
package fys_pkg;

  // Sizing of the sample list and of the stored indices
  localparam int MAX_WEIGHT  = 256;
  localparam int INDEX_BITS  = 24;
  localparam int POS_W       = $clog2(MAX_WEIGHT);
  localparam int CNT_W       = $clog2(MAX_WEIGHT + 1);

  // Fixed field widths
  localparam int RAND_W      = 32;
  localparam int COUNT_W     = 9;
  localparam int BOUND_W     = 24;
  localparam int OUT_VAL_W   = 24;
  localparam int OUT_POS_W   = 8;
  localparam int CFG_W       = 24;
  localparam int CFG_IDX_W   = 1;
  localparam int PROD_W      = RAND_W + BOUND_W;
  localparam int SUM_W       = BOUND_W + 1;

  // Register reset values
  localparam logic [COUNT_W-1:0] COUNT_RESET = COUNT_W'(134);
  localparam logic [BOUND_W-1:0] BOUND_RESET = BOUND_W'(24646);

  // Register indexes
  typedef enum logic [CFG_IDX_W-1:0] {
    REG_INDEX_COUNT = 1'b0,
    REG_INDEX_BOUND = 1'b1
  } cfg_reg_t;

  // Sequencer states
  typedef enum logic [2:0] {
    ST_IDLE,
    ST_MUL,
    ST_ADD,
    ST_SCAN,
    ST_DRAIN,
    ST_DECIDE
  } fys_state_t;

endpackage

FILE: design/fys_ram.sv
// Generic single-write, single-read RAM with registered read data.
module fys_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 16
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic                     re,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  // Write port
  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
  end

  // Registered read port
  always_ff @(posedge clk) begin
    if (re) begin
      rdata <= mem[raddr];
    end
  end

endmodule

FILE: design/fys_cand.sv
// Candidate unit: scales the random word into the range from the position up to the bound.
module fys_cand (
  input  logic                              clk,
  input  logic                              mul_en,
  input  logic [fys_pkg::RAND_W-1:0]        word,
  input  logic [fys_pkg::POS_W-1:0]         pos,
  input  logic [fys_pkg::BOUND_W-1:0]       bound,
  output logic [fys_pkg::INDEX_BITS-1:0]    cand
);

  logic [fys_pkg::BOUND_W-1:0] pos_ext;
  logic [fys_pkg::BOUND_W-1:0] factor;
  logic [fys_pkg::PROD_W-1:0]  prod;
  logic [fys_pkg::BOUND_W-1:0] prod_hi;
  logic [fys_pkg::SUM_W-1:0]   sum;

  // Range factor, zero where the bound does not exceed the position
  always_comb begin
    pos_ext = fys_pkg::BOUND_W'(pos);
    factor  = (bound > pos_ext) ? (bound - pos_ext) : '0;
    prod    = fys_pkg::PROD_W'(word) * fys_pkg::PROD_W'(factor);
  end

  // Hold the upper part of the product
  always_ff @(posedge clk) begin
    if (mul_en) begin
      prod_hi <= prod[fys_pkg::PROD_W-1:fys_pkg::RAND_W];
    end
  end

  // Offset by the position and mask to the index width
  always_comb begin
    sum  = fys_pkg::SUM_W'(prod_hi) + fys_pkg::SUM_W'(pos);
    cand = fys_pkg::INDEX_BITS'(sum);
  end

endmodule

FILE: design/fisher_yates_index_sampler.sv
// Top level of the Fisher-Yates index sampler: sequencer, duplicate scan and ports.
//
// Usage: each beat on the s_ channel carries one 32-bit random word and yields
// exactly one beat on the m_ channel: the index stored, its list position and
// tlast when position zero was written. A run fills positions from
// index_count-1 down to 0; the first beat after reset or after a completed run
// starts a new run and latches index_count and index_bound. Configuration
// writes on cfg_we/cfg_index/cfg_wdata take effect at the next run start.
// Each beat passes through the sequencer in order: multiply, add, a scan of
// every earlier list entry through the single compare unit reading the list
// RAM (one read port), a drain of the last read when any entry was scanned,
// and the store. s_tready is high only while the sequencer is idle, so a new
// word is taken only after the previous one has been stored. The result sits
// in an output register; a new word is accepted while it waits, but the next
// result stalls in the store step until the receiver takes the previous one.
// Reset (rst, synchronous) ends any run, drops any pending result and restores
// the register defaults; the list RAM needs no clearing as a run only reads
// entries it wrote itself.
module fisher_yates_index_sampler (
  input  logic                                clk,
  input  logic                                rst,
  // configuration write port
  input  logic                                cfg_we,
  input  logic [fys_pkg::CFG_IDX_W-1:0]       cfg_index,
  input  logic [fys_pkg::CFG_W-1:0]           cfg_wdata,
  // input beats
  input  logic                                s_tvalid,
  output logic                                s_tready,
  input  logic [31:0]                         s_tdata,   // [31:0] rand_word
  // result beats
  output logic                                m_tvalid,
  input  logic                                m_tready,
  output logic [31:0]                         m_tdata,   // [23:0] index_value, [31:24] list_position
  output logic                                m_tlast    // last_of_run
);

  // configuration registers
  logic [fys_pkg::COUNT_W-1:0]    index_count;
  logic [fys_pkg::BOUND_W-1:0]    index_bound;

  // run and item state
  fys_pkg::fys_state_t            state, state_next;
  logic                           run_active;
  logic [fys_pkg::CNT_W-1:0]      run_count;
  logic [fys_pkg::BOUND_W-1:0]    run_bound;
  logic [fys_pkg::POS_W-1:0]      next_position;
  logic [fys_pkg::POS_W-1:0]      pos;
  logic [fys_pkg::RAND_W-1:0]     word;
  logic [fys_pkg::INDEX_BITS-1:0] cand_reg;
  logic [fys_pkg::CNT_W-1:0]      scan_idx;
  logic                           cmp_pend;
  logic                           dup;

  // datapath signals
  logic [fys_pkg::CNT_W-1:0]      count_sat;
  logic [fys_pkg::INDEX_BITS-1:0] cand;
  logic [fys_pkg::INDEX_BITS-1:0] rd_data;
  logic [fys_pkg::INDEX_BITS-1:0] stored;
  logic [fys_pkg::CNT_W-1:0]      first_idx;
  logic                           in_beat;
  logic                           out_free;
  logic                           load_out;
  logic                           ram_re;
  logic                           mul_en;
  logic [fys_pkg::OUT_POS_W-1:0]  out_pos;

  assign in_beat  = s_tvalid && s_tready;
  assign out_free = !m_tvalid || m_tready;

  // Saturate the configured count to 1..MAX_WEIGHT
  always_comb begin
    if (index_count == '0) begin
      count_sat = fys_pkg::CNT_W'(1);
    end else if (32'(index_count) > fys_pkg::MAX_WEIGHT) begin
      count_sat = fys_pkg::CNT_W'(fys_pkg::MAX_WEIGHT);
    end else begin
      count_sat = fys_pkg::CNT_W'(index_count);
    end
  end

  // Configuration registers
  always_ff @(posedge clk) begin
    if (rst) begin
      index_count <= fys_pkg::COUNT_RESET;
      index_bound <= fys_pkg::BOUND_RESET;
    end else if (cfg_we) begin
      unique case (fys_pkg::cfg_reg_t'(cfg_index))
        fys_pkg::REG_INDEX_COUNT: index_count <= fys_pkg::COUNT_W'(cfg_wdata);
        fys_pkg::REG_INDEX_BOUND: index_bound <= fys_pkg::BOUND_W'(cfg_wdata);
      endcase
    end
  end

  // Candidate unit
  fys_cand u_cand (
    .clk    (clk),
    .mul_en (mul_en),
    .word   (word),
    .pos    (pos),
    .bound  (run_bound),
    .cand   (cand)
  );

  // Sample list
  fys_ram #(
    .WIDTH (fys_pkg::INDEX_BITS),
    .DEPTH (fys_pkg::MAX_WEIGHT)
  ) u_list (
    .clk   (clk),
    .we    (load_out),
    .waddr (pos),
    .wdata (stored),
    .re    (ram_re),
    .raddr (scan_idx[fys_pkg::POS_W-1:0]),
    .rdata (rd_data)
  );

  assign first_idx = fys_pkg::CNT_W'(pos) + fys_pkg::CNT_W'(1);
  assign stored    = dup ? fys_pkg::INDEX_BITS'(pos) : cand_reg;

  // Sequencer: next state and strobes
  always_comb begin
    state_next = state;
    s_tready   = 1'b0;
    mul_en     = 1'b0;
    ram_re     = 1'b0;
    load_out   = 1'b0;
    unique case (state)
      fys_pkg::ST_IDLE: begin
        s_tready = 1'b1;
        if (s_tvalid) begin
          state_next = fys_pkg::ST_MUL;
        end
      end
      fys_pkg::ST_MUL: begin
        mul_en     = 1'b1;
        state_next = fys_pkg::ST_ADD;
      end
      fys_pkg::ST_ADD: begin
        state_next = (first_idx < run_count) ? fys_pkg::ST_SCAN : fys_pkg::ST_DECIDE;
      end
      fys_pkg::ST_SCAN: begin
        ram_re = 1'b1;
        if (scan_idx + fys_pkg::CNT_W'(1) >= run_count) begin
          state_next = fys_pkg::ST_DRAIN;
        end
      end
      fys_pkg::ST_DRAIN: begin
        state_next = fys_pkg::ST_DECIDE;
      end
      fys_pkg::ST_DECIDE: begin
        if (out_free) begin
          load_out   = 1'b1;
          state_next = fys_pkg::ST_IDLE;
        end
      end
      default: state_next = fys_pkg::ST_IDLE;
    endcase
  end

  // State register
  always_ff @(posedge clk) begin
    if (rst) begin
      state <= fys_pkg::ST_IDLE;
    end else begin
      state <= state_next;
    end
  end

  // Run bookkeeping: latch the run on its first beat, step down on each store
  always_ff @(posedge clk) begin
    if (rst) begin
      run_active    <= 1'b0;
      run_count     <= '0;
      run_bound     <= '0;
      next_position <= '0;
    end else if (in_beat && !run_active) begin
      run_active <= 1'b1;
      run_count  <= count_sat;
      run_bound  <= index_bound;
    end else if (load_out) begin
      if (pos == '0) begin
        run_active    <= 1'b0;
        next_position <= '0;
      end else begin
        next_position <= pos - fys_pkg::POS_W'(1);
      end
    end
  end

  // Capture the word and its position
  always_ff @(posedge clk) begin
    if (in_beat) begin
      word <= s_tdata;
      pos  <= run_active ? next_position
                         : fys_pkg::POS_W'(count_sat - fys_pkg::CNT_W'(1));
    end
  end

  // Candidate hold and scan index
  always_ff @(posedge clk) begin
    if (state == fys_pkg::ST_ADD) begin
      cand_reg <= cand;
      scan_idx <= first_idx;
    end else if (ram_re) begin
      scan_idx <= scan_idx + fys_pkg::CNT_W'(1);
    end
  end

  // Compare unit: one list entry a cycle, accumulate any match
  always_ff @(posedge clk) begin
    if (rst) begin
      cmp_pend <= 1'b0;
      dup      <= 1'b0;
    end else begin
      cmp_pend <= ram_re;
      if (state == fys_pkg::ST_ADD) begin
        dup <= 1'b0;
      end else if (cmp_pend && (rd_data == cand_reg)) begin
        dup <= 1'b1;
      end
    end
  end

  // Output register
  assign out_pos = fys_pkg::OUT_POS_W'(pos);

  always_ff @(posedge clk) begin
    if (rst) begin
      m_tvalid <= 1'b0;
    end else if (load_out) begin
      m_tvalid <= 1'b1;
    end else if (m_tready) begin
      m_tvalid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (load_out) begin
      m_tdata <= {out_pos, fys_pkg::OUT_VAL_W'(stored)};
      m_tlast <= (pos == '0);
    end
  end

  // Scan reads only entries above the current position within the run
  a_scan_range: assert property (@(posedge clk) disable iff (rst)
    ram_re |-> (scan_idx > fys_pkg::CNT_W'(pos)) && (scan_idx < run_count))
    else $error("scan address outside written part of the list");

  // The list is never read and written in the same cycle
  a_no_rw_clash: assert property (@(posedge clk) disable iff (rst)
    !(ram_re && load_out))
    else $error("list read and write collide");

  // Storing position zero closes the run
  a_run_close: assert property (@(posedge clk) disable iff (rst)
    (load_out && (pos == '0)) |=> !run_active)
    else $error("run still active after position zero");

  // An active run always has a count within range
  a_count_range: assert property (@(posedge clk) disable iff (rst)
    run_active |-> (run_count != '0) &&
                   (32'(run_count) <= fys_pkg::MAX_WEIGHT))
    else $error("run count out of range");

  // A loaded result is offered on the next cycle with the stored position
  a_load_offer: assert property (@(posedge clk) disable iff (rst)
    load_out |=> m_tvalid && (m_tlast == (m_tdata[31:24] == '0)))
    else $error("result beat not offered after store");

endmodule

FILE: bench/tb_fisher_yates_index_sampler.sv
// Self-checking testbench for the Fisher-Yates index sampler: directed plan, then random runs.
`timescale 1ns / 100ps

module tb_fisher_yates_index_sampler;

  localparam int ITEM_TARGET = 1600;
  localparam int QUIET_TAIL  = 250;
  localparam int CYCLE_LIMIT = 3000000;
  localparam int PLAN_ROWS   = 24;

  // One sampled index as it leaves the block
  typedef struct packed {
    logic [23:0] value;
    logic [7:0]  pos;
    logic        last;
  } draw_t;

  typedef enum logic [1:0] {
    DO_WRITE,
    DO_WORD,
    DO_FINISH
  } plan_op_t;

  // Directed step: a register write, one word, or random words to the end of the run
  typedef struct packed {
    plan_op_t          op;
    fys_pkg::cfg_reg_t target;
    logic [23:0]       data;
    logic [31:0]       word;
    logic              typed;
    draw_t             want;
  } plan_row_t;

  logic                          clk = 1'b0;
  logic                          rst = 1'b1;
  logic                          cfg_we = 1'b0;
  logic [fys_pkg::CFG_IDX_W-1:0] cfg_index = '0;
  logic [fys_pkg::CFG_W-1:0]     cfg_wdata = '0;
  logic                          s_tvalid = 1'b0;
  logic                          s_tready;
  logic [31:0]                   s_tdata = '0;
  logic                          m_tvalid;
  logic                          m_tready = 1'b0;
  logic [31:0]                   m_tdata;
  logic                          m_tlast;

  // Mirror of the block: registers, latched run settings and the sample list
  logic [8:0]  cnt_reg = 9'd134;
  logic [23:0] bound_reg = 24'd24646;
  int          run_len = 0;
  logic [23:0] run_bound = '0;
  int          next_pos = 0;
  logic        run_live = 1'b0;
  logic [23:0] drawn_list [fys_pkg::MAX_WEIGHT];

  draw_t       pending_draws [$];
  plan_row_t   plan [PLAN_ROWS];
  int          errors = 0;
  int          cycle_count = 0;
  logic        calm = 1'b0;
  logic        quiet = 1'b0;

  fisher_yates_index_sampler uut (
    .clk      (clk),
    .rst      (rst),
    .cfg_we   (cfg_we),
    .cfg_index(cfg_index),
    .cfg_wdata(cfg_wdata),
    .s_tvalid (s_tvalid),
    .s_tready (s_tready),
    .s_tdata  (s_tdata),
    .m_tvalid (m_tvalid),
    .m_tready (m_tready),
    .m_tdata  (m_tdata),
    .m_tlast  (m_tlast)
  );

  always #6 clk = ~clk;

  // Work out the index stored for one random word and advance the run
  task automatic draw_index(input logic [31:0] word, output draw_t r);
    logic [7:0]  pos;
    logic [23:0] factor;
    logic [63:0] prod;
    logic [31:0] sum;
    logic        dup;
    if (!run_live) begin
      run_len   = (cnt_reg == 0) ? 1 :
                  ((cnt_reg > fys_pkg::MAX_WEIGHT) ? fys_pkg::MAX_WEIGHT : int'(cnt_reg));
      run_bound = bound_reg;
      next_pos  = run_len - 1;
      run_live  = 1'b1;
    end
    pos    = next_pos[7:0];
    factor = (run_bound > pos) ? run_bound - pos : 24'd0;
    prod   = {32'd0, word} * {40'd0, factor};
    sum    = pos + prod[63:32];
    // full scan of the tail, as the block does it
    dup = 1'b0;
    for (int j = int'(pos) + 1; j < run_len; j++)
      if (drawn_list[j] == sum[23:0]) dup = 1'b1;
    r.value = dup ? {16'd0, pos} : sum[23:0];
    r.pos   = pos;
    r.last  = (pos == 0);
    drawn_list[pos] = r.value;
    if (pos == 0) begin
      run_live = 1'b0;
      next_pos = 0;
    end else begin
      next_pos = pos - 1;
    end
  endtask

  // Offer one word, hold it until accepted, then queue its expected index
  task automatic send_word(input logic [31:0] word, input logic typed, input draw_t want);
    draw_t r;
    if (!quiet && !calm && $urandom_range(0, 3) == 0) begin
      s_tvalid <= 1'b0;
      repeat ($urandom_range(1, 10)) @(posedge clk);
    end
    s_tvalid <= 1'b1;
    s_tdata  <= word;
    do @(posedge clk); while (!s_tready);
    draw_index(word, r);
    pending_draws.push_back(typed ? want : r);
  endtask

  // Drop valid and wait until every queued index has come back
  task automatic settle();
    s_tvalid <= 1'b0;
    while (pending_draws.size() != 0) @(posedge clk);
    repeat (4) @(posedge clk);
  endtask

  task automatic write_reg(input fys_pkg::cfg_reg_t target, input logic [23:0] data);
    cfg_we    <= 1'b1;
    cfg_index <= target;
    cfg_wdata <= data;
    @(posedge clk);
    cfg_we <= 1'b0;
    if (target == fys_pkg::REG_INDEX_COUNT) cnt_reg = data[8:0];
    else bound_reg = data;
    @(posedge clk);
  endtask

  // Mostly short runs, now and then a long or saturated one
  function automatic logic [23:0] pick_count();
    int roll;
    logic [23:0] c;
    roll = $urandom_range(0, 99);
    if (roll < 70) c = 24'($urandom_range(1, 8));
    else if (roll < 90) c = 24'($urandom_range(9, 32));
    else if (roll < 96) c = 24'($urandom_range(33, 100));
    else if (roll < 98) c = 24'd0;
    else c = 24'($urandom_range(256, 511));
    // upper data bits are not part of the register
    if ($urandom_range(0, 3) == 0) c[23:9] = 15'($urandom);
    return c;
  endfunction

  // Tight bounds force duplicates; wide ones spread the indices
  function automatic logic [23:0] pick_bound();
    int roll;
    roll = $urandom_range(0, 9);
    if (roll < 4) return 24'($urandom_range(2, 40));
    else if (roll < 8) return 24'($urandom_range(2, 24'hFFFFFF));
    else if (roll < 9) return 24'hFFFFFF;
    else return 24'($urandom_range(2, 6));
  endfunction

  function automatic logic [31:0] pick_word();
    int roll;
    roll = $urandom_range(0, 15);
    if (roll == 0) return 32'h0;
    else if (roll == 1) return 32'hFFFFFFFF;
    else return $urandom;
  endfunction

  // Receiver: stall in bursts, none while calm or in the tail
  always @(posedge clk) begin : rx_ready
    int stall_left;
    if (stall_left > 0) begin
      stall_left--;
      m_tready <= 1'b0;
    end else if (!quiet && !calm && $urandom_range(0, 5) == 0) begin
      stall_left = $urandom_range(0, 9);
      m_tready <= 1'b0;
    end else begin
      m_tready <= 1'b1;
    end
  end

  // Compare each result beat with the oldest expected index
  always @(posedge clk) begin : rx_check
    draw_t got;
    draw_t want;
    if (!rst && m_tvalid && m_tready) begin
      got = '{m_tdata[23:0], m_tdata[31:24], m_tlast};
      if (pending_draws.size() == 0) begin
        $display("%0t: unexpected beat, got value %0d pos %0d last %0b",
                 $time, got.value, got.pos, got.last);
        errors++;
      end else begin
        want = pending_draws.pop_front();
        if (got.value !== want.value) begin
          $display("%0t: index_value expected %0d, got %0d", $time, want.value, got.value);
          errors++;
        end
        if (got.pos !== want.pos) begin
          $display("%0t: list_position expected %0d, got %0d", $time, want.pos, got.pos);
          errors++;
        end
        if (got.last !== want.last) begin
          $display("%0t: last_of_run expected %0b, got %0b", $time, want.last, got.last);
          errors++;
        end
      end
    end
  end

  // Cycle limit, and switch between calm and busy stretches
  always @(posedge clk) begin
    cycle_count++;
    if (cycle_count % 256 == 0) calm <= ($urandom_range(0, 2) == 0);
    if (cycle_count == CYCLE_LIMIT) begin
      $display("Verification failed");
      $finish;
    end
  end

  initial begin : stimulus
    int words_sent;
    int burst;
    draw_t none;
    none = '0;
    words_sent = 0;
    plan = '{
      // defaults after reset: count 134, bound 24646
      '{DO_WORD,   fys_pkg::REG_INDEX_COUNT, 24'd0, 32'h00000000, 1'b1, '{24'd133, 8'd133, 1'b0}},
      '{DO_WORD,   fys_pkg::REG_INDEX_COUNT, 24'd0, 32'hFFFFFFFF, 1'b1, '{24'd24645, 8'd132, 1'b0}},
      // written mid-run, applies from the next run
      '{DO_WRITE,  fys_pkg::REG_INDEX_COUNT, 24'd1, 32'h0, 1'b0, '0},
      '{DO_WRITE,  fys_pkg::REG_INDEX_BOUND, 24'd2, 32'h0, 1'b0, '0},
      '{DO_FINISH, fys_pkg::REG_INDEX_COUNT, 24'd0, 32'h0, 1'b0, '0},
      '{DO_WORD,   fys_pkg::REG_INDEX_COUNT, 24'd0, 32'hFFFFFFFF, 1'b1, '{24'd1, 8'd0, 1'b1}},
      '{DO_WORD,   fys_pkg::REG_INDEX_COUNT, 24'd0, 32'h00000000, 1'b1, '{24'd0, 8'd0, 1'b1}},
      // count zero runs as one
      '{DO_WRITE,  fys_pkg::REG_INDEX_COUNT, 24'd0, 32'h0, 1'b0, '0},
      '{DO_WORD,   fys_pkg::REG_INDEX_COUNT, 24'd0, 32'hFFFFFFFF, 1'b1, '{24'd1, 8'd0, 1'b1}},
      // duplicate falls back to the position
      '{DO_WRITE,  fys_pkg::REG_INDEX_COUNT, 24'd2, 32'h0, 1'b0, '0},
      '{DO_WORD,   fys_pkg::REG_INDEX_COUNT, 24'd0, 32'hFFFFFFFF, 1'b1, '{24'd1, 8'd1, 1'b0}},
      '{DO_WORD,   fys_pkg::REG_INDEX_COUNT, 24'd0, 32'hFFFFFFFF, 1'b1, '{24'd0, 8'd0, 1'b1}},
      // bound not above the position gives the position itself
      '{DO_WRITE,  fys_pkg::REG_INDEX_COUNT, 24'd5, 32'h0, 1'b0, '0},
      '{DO_WRITE,  fys_pkg::REG_INDEX_BOUND, 24'd3, 32'h0, 1'b0, '0},
      '{DO_WORD,   fys_pkg::REG_INDEX_COUNT, 24'd0, 32'hFFFFFFFF, 1'b1, '{24'd4, 8'd4, 1'b0}},
      '{DO_WORD,   fys_pkg::REG_INDEX_COUNT, 24'd0, 32'h00000000, 1'b1, '{24'd3, 8'd3, 1'b0}},
      '{DO_WORD,   fys_pkg::REG_INDEX_COUNT, 24'd0, 32'h12345678, 1'b1, '{24'd2, 8'd2, 1'b0}},
      '{DO_WORD,   fys_pkg::REG_INDEX_COUNT, 24'd0, 32'hFFFFFFFF, 1'b1, '{24'd1, 8'd1, 1'b0}},
      '{DO_WORD,   fys_pkg::REG_INDEX_COUNT, 24'd0, 32'hFFFFFFFF, 1'b1, '{24'd0, 8'd0, 1'b1}},
      // oversized count saturates, widest bound
      '{DO_WRITE,  fys_pkg::REG_INDEX_COUNT, 24'hFFFFFF, 32'h0, 1'b0, '0},
      '{DO_WRITE,  fys_pkg::REG_INDEX_BOUND, 24'hFFFFFF, 32'h0, 1'b0, '0},
      '{DO_WORD,   fys_pkg::REG_INDEX_COUNT, 24'd0, 32'h00000000, 1'b1, '{24'd255, 8'd255, 1'b0}},
      '{DO_WORD,   fys_pkg::REG_INDEX_COUNT, 24'd0, 32'hFFFFFFFF, 1'b1,
        '{24'd16777214, 8'd254, 1'b0}},
      '{DO_FINISH, fys_pkg::REG_INDEX_COUNT, 24'd0, 32'h0, 1'b0, '0}
    };

    repeat (5) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);

    // Directed plan
    foreach (plan[i]) begin
      case (plan[i].op)
        DO_WRITE: begin
          settle();
          write_reg(plan[i].target, plan[i].data);
        end
        DO_WORD: begin
          send_word(plan[i].word, plan[i].typed, plan[i].want);
        end
        default: begin
          while (run_live) send_word(pick_word(), 1'b0, none);
        end
      endcase
    end

    // Random runs, reconfigured mostly between runs and sometimes mid-run
    while (words_sent < ITEM_TARGET) begin
      if (!run_live || $urandom_range(0, 7) == 0) begin
        settle();
        if ($urandom_range(0, 2) != 0) write_reg(fys_pkg::REG_INDEX_COUNT, pick_count());
        if ($urandom_range(0, 2) != 0) write_reg(fys_pkg::REG_INDEX_BOUND, pick_bound());
      end
      burst = $urandom_range(1, 12);
      repeat (burst) begin
        if (words_sent == ITEM_TARGET - QUIET_TAIL) quiet <= 1'b1;
        send_word(pick_word(), 1'b0, none);
        words_sent++;
      end
    end

    s_tvalid <= 1'b0;
    while (pending_draws.size() != 0) @(posedge clk);
    repeat (20) @(posedge clk);
    if (errors == 0) begin
      $display("Verification passed");
    end else begin
      $display("Verification failed");
    end
    $finish;
  end

endmodule
